// ===== hw/rtl/urad_pkg.sv =====
// Shared types, constants and the digit-to-character function for the radix converter.
package urad_pkg;

    // Field widths of the input and result words.
    localparam int VAL_W   = 64;
    localparam int RADIX_W = 6;
    localparam int MIND_W  = 7;
    localparam int CHAR_W  = 8;
    localparam int DIG_W   = 6;

    // Valid radix range.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // Quotient bits resolved per divider cycle.
    localparam int CHUNK = 8;

    // Character constants.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 8'h41;
    localparam logic [CHAR_W-1:0] DEC_BASE   = 8'd10;

    // Classified conversion request, as held in the command queue.
    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [RADIX_W-1:0] radix;
        logic [MIND_W-1:0]  pad;
        logic               err;
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              is_last;
        logic [MIND_W-1:0] digit_total;
        logic              radix_error;
    } t_res;

    // Digit value to character: 0-9 then A-Z.
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = CHAR_W'(d);
        if (dw < DEC_BASE) begin
            return ASCII_ZERO + dw;
        end
        return ASCII_A + dw - DEC_BASE;
    endfunction

endpackage

// ===== hw/rtl/urad_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module urad_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/urad_front.sv =====
// Front end: accepts requests, checks the radix, masks the value, clamps padding and queues them.
module urad_front #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [63:0]          i_value,
    input  logic [5:0]           i_radix,
    input  logic [6:0]           i_min_digits,
    output logic                 o_head_valid,
    output urad_pkg::t_cmd       o_head,
    input  logic                 i_head_pop
);

    import urad_pkg::*;

    localparam int QD = 2;
    localparam logic [VAL_W-1:0] VMASK = {VAL_W{1'b1}} >> (VAL_W - VALUE_BITS);

    t_cmd       cls;
    logic       wr_en;
    t_cmd       r_mem [0:QD-1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;

    // Classify the incoming word.
    always_comb begin
        cls.value = i_value & VMASK;
        cls.radix = i_radix;
        cls.err   = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
        if (i_min_digits > MIND_W'(MAX_DIGITS)) begin
            cls.pad = MIND_W'(MAX_DIGITS);
        end else begin
            cls.pad = i_min_digits;
        end
    end

    assign full         = (r_cnt == 2'(QD));
    assign wr_en        = push && !full;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

    // Queue pointers and fill level.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wp = ~r_wp;
        end
        if (i_head_pop) begin
            n_rp = ~r_rp;
        end
        if (wr_en && !i_head_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!wr_en && i_head_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= cls;
        end
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QD))
        else $error("command queue fill level out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_pop |-> (r_cnt != '0))
        else $error("command taken from an empty queue");
`endif

endmodule

// ===== hw/rtl/urad_back.sv =====
// Back end: serial division by the radix, digit store, and most-significant-first emission.
module urad_back #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  urad_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      o_digit_char,
    output logic            o_is_last,
    output logic [6:0]      o_digit_total,
    output logic            o_radix_error
);

    import urad_pkg::*;

    localparam int QW  = ((VALUE_BITS + CHUNK - 1) / CHUNK) * CHUNK;
    localparam int NCH = QW / CHUNK;
    localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW  = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_SEND  = 3'd4;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [QW-1:0]      r_q;
    logic [QW-1:0]      n_q;
    logic [DIG_W-1:0]   r_rem;
    logic [DIG_W-1:0]   n_rem;
    logic [RADIX_W-1:0] r_radix;
    logic [RADIX_W-1:0] n_radix;
    logic [CW-1:0]      r_pad;
    logic [CW-1:0]      n_pad;
    logic [CHW-1:0]     r_chk;
    logic [CHW-1:0]     n_chk;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic [CW-1:0]      r_tot;
    logic [CW-1:0]      n_tot;
    logic [CW-1:0]      r_p;
    logic [CW-1:0]      n_p;
    t_res               r_out;
    t_res               n_out;
    logic               r_out_valid;
    logic               n_out_valid;

    logic [QW-1:0]      div_q;
    logic [DIG_W-1:0]   div_rem;
    logic [CW-1:0]      cnt_inc;
    logic [CW-1:0]      tot;
    logic               slot_free;
    logic               ram_we;
    logic               ram_re;
    logic [DIG_W-1:0]   ram_rdata;

    // Eight restoring long-division steps per cycle on the top byte of the quotient register.
    always_comb begin
        logic [DIG_W:0]   t;
        logic [DIG_W-1:0] rem;
        logic [CHUNK-1:0] chunk;
        logic [CHUNK-1:0] qbits;
        rem   = r_rem;
        chunk = r_q[QW-1 -: CHUNK];
        qbits = '0;
        t     = '0;
        for (int i = 0; i < CHUNK; i++) begin
            t = {rem, chunk[CHUNK-1-i]};
            if (t >= {1'b0, r_radix}) begin
                t = t - {1'b0, r_radix};
                qbits[CHUNK-1-i] = 1'b1;
            end
            rem = t[DIG_W-1:0];
        end
        div_rem = rem;
        div_q   = QW'({r_q, qbits});
    end

    assign slot_free = !r_out_valid || pop;
    assign cnt_inc   = r_cnt + CW'(1);
    assign tot       = (r_pad > cnt_inc) ? r_pad : cnt_inc;

    // Sequencer: error word on a bad radix, else divide digit by digit and read digits back.
    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_pad       = r_pad;
        n_chk       = r_chk;
        n_cnt       = r_cnt;
        n_tot       = r_tot;
        n_p         = r_p;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.err) begin
                        if (slot_free) begin
                            o_cmd_pop         = 1'b1;
                            n_out.digit_char  = '0;
                            n_out.is_last     = 1'b1;
                            n_out.digit_total = '0;
                            n_out.radix_error = 1'b1;
                            n_out_valid       = 1'b1;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_q       = QW'(i_cmd.value);
                        n_rem     = '0;
                        n_radix   = i_cmd.radix;
                        n_pad     = CW'(i_cmd.pad);
                        n_chk     = '0;
                        n_cnt     = '0;
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_q   = div_q;
                n_rem = div_rem;
                n_chk = r_chk + CHW'(1);
                if (r_chk == CHW'(NCH - 1)) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                ram_we = 1'b1;
                n_cnt  = cnt_inc;
                n_rem  = '0;
                n_chk  = '0;
                if ((r_q == '0) || (r_cnt == CW'(MAX_DIGITS - 1))) begin
                    n_tot   = tot;
                    n_p     = tot - CW'(1);
                    n_state = ST_READ;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_READ: begin
                ram_re  = 1'b1;
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (slot_free) begin
                    if (r_p >= r_cnt) begin
                        n_out.digit_char = ASCII_ZERO;
                    end else begin
                        n_out.digit_char = to_ascii(ram_rdata);
                    end
                    n_out.is_last     = (r_p == '0);
                    n_out.digit_total = MIND_W'(r_tot);
                    n_out.radix_error = 1'b0;
                    n_out_valid       = 1'b1;
                    if (r_p == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_p     = r_p - CW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_q         <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_q         <= n_q;
            r_cnt       <= n_cnt;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_pad   <= n_pad;
        r_chk   <= n_chk;
        r_tot   <= n_tot;
        r_p     <= n_p;
        r_out   <= n_out;
    end

    // Digit store, least significant digit at address zero.
    urad_ram #(
        .WIDTH (DIG_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (r_rem),
        .i_re    (ram_re),
        .i_raddr (r_p[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign empty         = !r_out_valid;
    assign o_digit_char  = r_out.digit_char;
    assign o_is_last     = r_out.is_last;
    assign o_digit_total = r_out.digit_total;
    assign o_radix_error = r_out.radix_error;

`ifndef SYNTHESIS
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.radix_error) |-> (r_out.is_last && (r_out.digit_total == '0)))
        else $error("error word is not a single terminal word");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_READ) || (r_state == ST_SEND)) |-> (r_p < r_tot))
        else $error("emission index beyond character count");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");
`endif

endmodule

// ===== hw/rtl/uint_to_radix_ascii.sv =====
// Unsigned integer to ASCII digits in radix 2..36, with zero padding, one character per word.
// Per request: each digit comes from a byte-wide serial divider followed by a store step, then
// each character takes a digit store read and an output load.
// A bad radix gives a single error word. Requests pass through the command queue to the back end.
// A two-entry command queue lets requests be taken while a conversion is running.
// Synchronous active-low reset empties the queue and the output; the digit store is not cleared.
module uint_to_radix_ascii #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_value,
    input  logic [5:0]  i_radix,
    input  logic [6:0]  i_min_digits,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_digit_char,
    output logic        o_is_last,
    output logic [6:0]  o_digit_total,
    output logic        o_radix_error
);

    import urad_pkg::*;

    logic head_valid;
    t_cmd head;
    logic head_pop;

    // Request intake and classification.
    urad_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .i_min_digits (i_min_digits),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_pop   (head_pop)
    );

    // Conversion and character output.
    urad_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (head_valid),
        .i_cmd         (head),
        .o_cmd_pop     (head_pop),
        .empty         (empty),
        .pop           (pop),
        .o_digit_char  (o_digit_char),
        .o_is_last     (o_is_last),
        .o_digit_total (o_digit_total),
        .o_radix_error (o_radix_error)
    );

endmodule

// ===== tb/sv/uint_to_radix_ascii_tb.sv =====
// Self-checking testbench for the unsigned integer to radix ASCII converter.
`timescale 1ns / 100ps

module uint_to_radix_ascii_tb;

    import urad_pkg::*;

    // Digit store capacity of the block as instantiated.
    localparam int DIGIT_CAP = 64;
    // Cycles to wait after the last word: one full-length radix 2 conversion and margin.
    localparam int SETTLE_CYCLES = 900;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [63:0] i_value;
    logic [5:0]  i_radix;
    logic [6:0]  i_min_digits;
    logic        empty;
    logic        pop;
    logic [7:0]  o_digit_char;
    logic        o_is_last;
    logic [6:0]  o_digit_total;
    logic        o_radix_error;

    // Characters still to come, oldest first.
    t_res pending_chars[$];
    int   mismatch_count = 0;

    uint_to_radix_ascii #(
        .VALUE_BITS(64),
        .MAX_DIGITS(DIGIT_CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_value       (i_value),
        .i_radix       (i_radix),
        .i_min_digits  (i_min_digits),
        .empty         (empty),
        .pop           (pop),
        .o_digit_char  (o_digit_char),
        .o_is_last     (o_is_last),
        .o_digit_total (o_digit_total),
        .o_radix_error (o_radix_error)
    );

    // Free-running 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return $urandom_range(10, 40);
        end else if (roll < 7) begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    // Work out the characters one request should produce and queue them.
    function automatic void predict_conversion(input logic [63:0] v, input logic [5:0] r,
                                               input logic [6:0] m);
        logic [5:0]  digits [DIGIT_CAP];
        logic [63:0] rest;
        logic [7:0]  dw;
        int          count;
        int          pad_to;
        t_res        word;
        if (r < RADIX_MIN || r > RADIX_MAX) begin
            word = '{digit_char: '0, is_last: 1'b1, digit_total: '0, radix_error: 1'b1};
            pending_chars.push_back(word);
            return;
        end
        // Repeated division yields the digits least significant first.
        rest  = v;
        count = 0;
        do begin
            digits[count] = 6'(rest % 64'(r));
            rest          = rest / 64'(r);
            count++;
        end while (rest != 64'd0 && count < DIGIT_CAP);
        // Left padding with zeros, capped at the store size.
        pad_to = (int'(m) > DIGIT_CAP) ? DIGIT_CAP : int'(m);
        while (count < pad_to) begin
            digits[count] = '0;
            count++;
        end
        // Characters go out most significant first.
        for (int k = 0; k < count; k++) begin
            dw = 8'(digits[count - 1 - k]);
            word.digit_char  = (dw < DEC_BASE) ? ASCII_ZERO + dw : ASCII_A + dw - DEC_BASE;
            word.is_last     = (k == count - 1);
            word.digit_total = 7'(count);
            word.radix_error = 1'b0;
            pending_chars.push_back(word);
        end
    endfunction

    // Offer one request and hold it until the block takes it; push stays high afterwards.
    task automatic send_number(input logic [63:0] v, input logic [5:0] r,
                               input logic [6:0] m, input bit eager);
        int gap;
        gap = eager ? 0 : random_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_value      <= v;
        i_radix      <= r;
        i_min_digits <= m;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_conversion(v, r, m);
    endtask

    // Hold off the sender until every outstanding character has been taken.
    task automatic drain_results();
        push <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // Extreme values and characters at the ends of the digit range.
    task automatic test_extreme_values();
        send_number(64'd0, 6'd10, 7'd0, 1'b0);
        send_number('1, 6'd2, 7'd0, 1'b0);
        send_number('1, 6'd16, 7'd0, 1'b0);
        send_number('1, 6'd36, 7'd0, 1'b0);
        send_number('1, 6'd10, 7'd0, 1'b0);
        send_number('1, 6'd3, 7'd0, 1'b0);
        send_number(64'h8000_0000_0000_0000, 6'd2, 7'd0, 1'b0);
        send_number(64'd35, 6'd36, 7'd0, 1'b0);
        send_number(64'd10, 6'd11, 7'd0, 1'b0);
        send_number(64'd9, 6'd10, 7'd0, 1'b1);
        send_number(64'd1, 6'd2, 7'd0, 1'b1);
    endtask

    // Radix values outside the valid range each give one error word.
    task automatic test_bad_radix();
        send_number(64'd123, 6'd0, 7'd0, 1'b0);
        send_number(64'd123, 6'd1, 7'd5, 1'b0);
        send_number('1, 6'd37, 7'd127, 1'b1);
        send_number(64'd0, 6'd63, 7'd64, 1'b1);
    endtask

    // Zero padding, including requests above the store capacity.
    task automatic test_padding();
        send_number(64'd7, 6'd10, 7'd5, 1'b0);
        send_number(64'd12345, 6'd10, 7'd3, 1'b0);
        send_number(64'd0, 6'd2, 7'd64, 1'b0);
        send_number(64'd255, 6'd16, 7'd65, 1'b0);
        send_number(64'd0, 6'd36, 7'd127, 1'b0);
        send_number(64'd1, 6'd8, 7'd1, 1'b1);
    endtask

    // Random requests in bursts and with gaps; the sender drains now and then.
    task automatic test_random_numbers();
        logic [63:0] v;
        logic [5:0]  r;
        logic [6:0]  m;
        bit          eager;
        int          roll;
        eager = 1'b0;
        for (int n = 0; n < 190; n++) begin
            if (n % 25 == 0) begin
                eager = ($urandom_range(0, 3) == 0);
            end
            if (n % 40 == 39) begin
                drain_results();
            end
            // Spread the value size so that most conversions stay short.
            v = {$urandom, $urandom} >> $urandom_range(0, 63);
            r = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(2, 36));
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                m = '0;
            end else if (roll < 9) begin
                m = 7'($urandom_range(1, 24));
            end else begin
                m = 7'($urandom_range(25, 127));
            end
            send_number(v, r, m, eager);
        end
    endtask

    // Receiver: ready stretches, short stalls and the odd long one.
    initial begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm_left > 0) begin
                calm_left--;
                pop <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 29) == 0) begin
                    calm_left = $urandom_range(50, 300);
                end else begin
                    stall_left = random_gap();
                end
            end
        end
    end

    // Each word taken from the block is compared with the oldest expected one.
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && pop && !empty) begin
            got = '{digit_char: o_digit_char, is_last: o_is_last,
                    digit_total: o_digit_total, radix_error: o_radix_error};
            if (pending_chars.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word char=%h last=%b total=%0d err=%b", $time,
                         got.digit_char, got.is_last, got.digit_total, got.radix_error);
            end else begin
                want = pending_chars.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display("%0t: expected char=%h last=%b total=%0d err=%b", $time,
                             want.digit_char, want.is_last, want.digit_total,
                             want.radix_error);
                    $display("%0t: actual   char=%h last=%b total=%0d err=%b", $time,
                             got.digit_char, got.is_last, got.digit_total, got.radix_error);
                end
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_value      <= '0;
        i_radix      <= '0;
        i_min_digits <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_values();
        test_bad_radix();
        test_padding();
        test_random_numbers();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("uint_to_radix_ascii: match");
        end else begin
            $display("uint_to_radix_ascii: mismatch");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #30ms;
        $display("uint_to_radix_ascii: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/urad_pkg.sv
hw/rtl/urad_ram.sv
hw/rtl/urad_front.sv
hw/rtl/urad_back.sv
hw/rtl/uint_to_radix_ascii.sv
tb/sv/uint_to_radix_ascii_tb.sv
